// ===== hdl/wosa_pkg.sv =====
// Types and constants shared by the wired-OR signal aggregator.
package wosa_pkg;

    localparam int TBL_CONNS = 8;

    localparam logic [1:0] CFG_INT_SIGNAL_TABLE = 2'd0;
    localparam logic [1:0] CFG_INT_SIGNAL_VALID = 2'd1;
    localparam logic [1:0] CFG_VECTOR_TABLE     = 2'd2;
    localparam logic [1:0] CFG_VECTOR_VALID     = 2'd3;

    typedef enum logic [2:0] {
        ST_ABSORBED  = 3'd0,
        ST_PROPAGATE = 3'd1,
        ST_DROPPED   = 3'd2,
        ST_ACK_FOUND = 3'd3,
        ST_ACK_NONE  = 3'd4
    } t_status;

    typedef struct packed {
        logic       mode;
        logic [2:0] source;
        logic [3:0] signal_id;
        logic       unspecified_int;
        logic       level;
        logic       edge_flag;
    } t_in_item;

    typedef struct packed {
        t_status    status;
        logic [3:0] signal_out;
        logic       level_out;
        logic       edge_out;
        logic [2:0] skip_connection;
        logic [2:0] ack_connection;
        logic [7:0] vector_out;
        logic       vector_defined;
    } t_out_item;

    typedef struct packed {
        logic [31:0] int_signal_table;
        logic [7:0]  int_signal_valid;
        logic [63:0] vector_table;
        logic [7:0]  vector_valid;
    } t_cfg;

    typedef struct packed {
        logic       en;
        logic       set;
        logic [2:0] src;
        logic [3:0] sig;
    } t_upd;

endpackage

// ===== hdl/wosa_in_if.sv =====
// Input channel carrying edge and acknowledge beats.
interface wosa_in_if;
    logic               valid;
    logic               ready;
    wosa_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/wosa_out_if.sv =====
// Output channel carrying result beats.
interface wosa_out_if;
    logic                valid;
    logic                ready;
    wosa_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/wosa_cfg.sv =====
// Configuration registers written through the plain write port.
module wosa_cfg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_idx,
    input  logic [63:0]    i_cfg_data,
    output wosa_pkg::t_cfg o_cfg
);
    import wosa_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_INT_SIGNAL_TABLE: r_cfg.int_signal_table <= i_cfg_data[31:0];
                CFG_INT_SIGNAL_VALID: r_cfg.int_signal_valid <= i_cfg_data[7:0];
                CFG_VECTOR_TABLE:     r_cfg.vector_table     <= i_cfg_data;
                CFG_VECTOR_VALID:     r_cfg.vector_valid     <= i_cfg_data[7:0];
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule

// ===== hdl/wosa_state.sv =====
// Per-connection assert bits and per-signal assert counts.
module wosa_state #(
    parameter int CONNECTIONS = 8,
    parameter int SIGNALS     = 16,
    parameter int CNTW        = $clog2(CONNECTIONS + 1)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  wosa_pkg::t_upd                      i_upd,
    output logic [CONNECTIONS-1:0][SIGNALS-1:0] o_bits,
    output logic [SIGNALS-1:0][CNTW-1:0]        o_counts
);
    import wosa_pkg::*;

    localparam int CW = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;
    localparam int SW = (SIGNALS > 1) ? $clog2(SIGNALS) : 1;

    logic [CONNECTIONS-1:0][SIGNALS-1:0] r_bits;
    logic [SIGNALS-1:0][CNTW-1:0]        r_counts;
    logic [CW-1:0]                       w_c;
    logic [SW-1:0]                       w_s;

    assign w_c = CW'(i_upd.src);
    assign w_s = SW'(i_upd.sig);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits   <= '0;
            r_counts <= '0;
        end else if (i_upd.en) begin
            r_bits[w_c][w_s] <= i_upd.set;
            if (i_upd.set) begin
                r_counts[w_s] <= r_counts[w_s] + CNTW'(1);
            end else begin
                r_counts[w_s] <= r_counts[w_s] - CNTW'(1);
            end
        end
    end

    assign o_bits   = r_bits;
    assign o_counts = r_counts;
endmodule

// ===== hdl/wosa_eval.sv =====
// Resolve one registered beat into a result and a state update.
module wosa_eval #(
    parameter int CONNECTIONS = 8,
    parameter int SIGNALS     = 16,
    parameter int CNTW        = $clog2(CONNECTIONS + 1)
) (
    input  wosa_pkg::t_in_item                  i_item,
    input  wosa_pkg::t_cfg                      i_cfg,
    input  logic [CONNECTIONS-1:0][SIGNALS-1:0] i_bits,
    input  logic [SIGNALS-1:0][CNTW-1:0]        i_counts,
    output wosa_pkg::t_out_item                 o_res,
    output wosa_pkg::t_upd                      o_upd
);
    import wosa_pkg::*;

    localparam int CW = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;
    localparam int SW = (SIGNALS > 1) ? $clog2(SIGNALS) : 1;

    logic          w_found;
    logic [CW-1:0] w_idx;
    logic [3:0]    w_cfg_sig;
    logic [3:0]    w_sig;
    logic          w_held;
    logic [CNTW-1:0] w_cnt;
    logic          w_prop;

    // lowest asserting connection for the acknowledged signal
    always_comb begin
        w_found = 1'b0;
        w_idx   = '0;
        for (int c = CONNECTIONS - 1; c >= 0; c--) begin
            if (i_bits[c][SW'(i_item.signal_id)]) begin
                w_found = 1'b1;
                w_idx   = CW'(c);
            end
        end
    end

    assign w_cfg_sig = i_cfg.int_signal_table[4*i_item.source +: 4];
    assign w_sig     = i_item.unspecified_int ? w_cfg_sig : i_item.signal_id;
    assign w_held    = i_bits[CW'(i_item.source)][SW'(w_sig)];
    assign w_cnt     = i_counts[SW'(w_sig)];

    always_comb begin
        o_res  = '0;
        o_upd  = '0;
        w_prop = 1'b0;
        o_res.status = ST_ABSORBED;
        if (i_item.mode) begin
            o_res.signal_out = i_item.signal_id;
            if (int'(i_item.signal_id) < SIGNALS && w_found) begin
                o_res.status         = ST_ACK_FOUND;
                o_res.ack_connection = 3'(w_idx);
                if (int'(w_idx) < TBL_CONNS && i_cfg.vector_valid[3'(w_idx)]) begin
                    o_res.vector_defined = 1'b1;
                    o_res.vector_out     = i_cfg.vector_table[8*(3'(w_idx)) +: 8];
                end
            end else begin
                o_res.status = ST_ACK_NONE;
            end
        end else if (int'(i_item.source) >= CONNECTIONS) begin
            o_res.signal_out = i_item.signal_id;
        end else if (i_item.unspecified_int
                     && (!i_cfg.int_signal_valid[i_item.source]
                         || int'(w_cfg_sig) >= SIGNALS)) begin
            o_res.status = ST_DROPPED;
        end else if (int'(w_sig) >= SIGNALS) begin
            o_res.signal_out = w_sig;
        end else begin
            o_res.signal_out = w_sig;
            o_upd.src        = i_item.source;
            o_upd.sig        = w_sig;
            o_upd.set        = i_item.level;
            if (i_item.level) begin
                o_upd.en = !w_held;
                w_prop   = !w_held && (w_cnt == '0);
            end else if (w_held) begin
                o_upd.en = 1'b1;
                w_prop   = (w_cnt == CNTW'(1));
            end else begin
                w_prop = i_item.edge_flag && (w_cnt == '0);
            end
            if (w_prop) begin
                o_res.status          = ST_PROPAGATE;
                o_res.level_out       = i_item.level;
                o_res.edge_out        = i_item.edge_flag;
                o_res.skip_connection = i_item.source;
            end
        end
    end
endmodule

// ===== hdl/wired_or_signal_aggregator.sv =====
// Top level of the wired-OR bus signal aggregator.
// Each beat (signal edge or interrupt acknowledge) yields exactly one result beat. A beat is
// captured in an input register, resolved combinationally against the assert bit matrix and the
// per-signal counts, and lands in an output register when the output side can take it; one
// beat is accepted every cycle while the output side keeps taking results. The state update of
// a beat is written in the same cycle its result is registered, so the next beat always sees
// it. Configuration registers reset to zero; the user must write them only while the block is
// idle, which the block itself does not enforce.
module wired_or_signal_aggregator #(
    parameter int CONNECTIONS = 8,
    parameter int SIGNALS     = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wosa_in_if.sink     i_in,
    wosa_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);
    import wosa_pkg::*;

    localparam int CNTW = $clog2(CONNECTIONS + 1);

    logic      r_iv;
    t_in_item  r_item;
    logic      r_ov;
    t_out_item r_out;

    t_cfg      w_cfg;
    t_out_item w_res;
    t_upd      w_upd;
    t_upd      w_upd_q;
    logic      w_adv;
    logic      w_mismatch;

    logic [CONNECTIONS-1:0][SIGNALS-1:0] w_bits;
    logic [SIGNALS-1:0][CNTW-1:0]        w_counts;

    assign w_adv      = r_iv && (!r_ov || o_out.ready);
    assign i_in.ready = !r_iv || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_iv <= i_in.valid;
            end
            if (!r_ov || o_out.ready) begin
                r_ov <= r_iv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item <= i_in.data;
        end
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;

    wosa_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    wosa_eval #(
        .CONNECTIONS (CONNECTIONS),
        .SIGNALS     (SIGNALS),
        .CNTW        (CNTW)
    ) u_eval (
        .i_item   (r_item),
        .i_cfg    (w_cfg),
        .i_bits   (w_bits),
        .i_counts (w_counts),
        .o_res    (w_res),
        .o_upd    (w_upd)
    );

    always_comb begin
        w_upd_q    = w_upd;
        w_upd_q.en = w_upd.en && w_adv;
    end

    wosa_state #(
        .CONNECTIONS (CONNECTIONS),
        .SIGNALS     (SIGNALS),
        .CNTW        (CNTW)
    ) u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_upd    (w_upd_q),
        .o_bits   (w_bits),
        .o_counts (w_counts)
    );

    // a zero count must match an empty column of assert bits
    always_comb begin
        w_mismatch = 1'b0;
        for (int s = 0; s < SIGNALS; s++) begin
            logic any;
            any = 1'b0;
            for (int c = 0; c < CONNECTIONS; c++) begin
                any = any | w_bits[c][s];
            end
            if ((w_counts[s] == '0) == any) begin
                w_mismatch = 1'b1;
            end
        end
    end

    a_count_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n) !w_mismatch)
        else $error("assert count disagrees with assert bits");

    a_upd_applied: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_upd_q.en |=> w_bits[$past(w_upd_q.src)][$past(w_upd_q.sig)] == $past(w_upd_q.set))
        else $error("state update not applied");

    a_vector_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_out.vector_defined) |-> r_out.vector_out == '0)
        else $error("undefined vector carries data");

    a_prop_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out.status != ST_PROPAGATE)
            |-> (!r_out.level_out && !r_out.edge_out && r_out.skip_connection == '0))
        else $error("broadcast fields set without propagation");
endmodule
